FILE: design/ft3d_pkg.sv
// ----------------------------------------------------------------------------
// ft3d_pkg
// Shared widths, reset values and command codes for the 3-D binary indexed
// tree block and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ft3d_pkg;

  localparam int DEF_MAX_SIDE = 16;
  localparam int SIDE_W       = 5;
  localparam int DATA_W       = 32;

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(16);

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_SUM = 1'b1;

endpackage

`default_nettype wire

FILE: design/ft3d_ram.sv
// ----------------------------------------------------------------------------
// ft3d_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read data output.
// ----------------------------------------------------------------------------
`default_nettype none

module ft3d_ram import ft3d_pkg::*; #(
  parameter int ADDR_W = 12,
  parameter int WIDTH  = DATA_W
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/fenwick_tree_3d_range_sum.sv
// ----------------------------------------------------------------------------
// fenwick_tree_3d_range_sum
// Three-dimensional binary indexed tree held in one synchronous RAM, with
// point add and inclusive box sum by eight prefix walks.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                Payload
//   cfg      in         cfg_write                cfg_data (side_size)
//   in       in         in_valid / in_stall      cmd, low and high corner, value
//   out      out        out_valid / out_stall    box_sum
//
// A point add reads and then writes back each tree cell that it touches, up to
// (log2(n) + 1)^3 cells. A box sum runs one prefix walk per corner, eight in
// all, reading each tree cell and adding or subtracting it, then loads the
// result. Each cell visit waits on the single RAM read port and its registered
// read data. After reset a clearing pass writes zero to every RAM word, with
// in_stall held high. A new transaction is taken while a finished sum waits on
// out_stall; the next sum then holds until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module fenwick_tree_3d_range_sum import ft3d_pkg::*; #(
  parameter int MAX_SIDE = DEF_MAX_SIDE
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [SIDE_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     cmd,
  input  logic [SIDE_W-1:0]        x_low,
  input  logic [SIDE_W-1:0]        y_low,
  input  logic [SIDE_W-1:0]        z_low,
  input  logic [SIDE_W-1:0]        x_high,
  input  logic [SIDE_W-1:0]        y_high,
  input  logic [SIDE_W-1:0]        z_high,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] box_sum
);

  localparam int CW = $clog2(MAX_SIDE + 1);
  // Coordinate width: holds any input code and twice the side.
  localparam int KW = ((CW > SIDE_W) ? CW : SIDE_W) + 1;
  localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int AD = 3 * AW;
  localparam logic [KW-1:0] MAX_K = KW'(MAX_SIDE);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_Q_START,
    ST_Q_RD,
    ST_Q_ACC,
    ST_Q_DONE
  } state_t;

  state_t            state;
  logic [SIDE_W-1:0] side_size;
  logic [AD-1:0]     clr_addr;
  logic [2:0]        corner;
  logic              up;
  logic [KW-1:0]     i, j, k;
  logic [KW-1:0]     sj, sk;
  logic [KW-1:0]     x1, y1, z1, x2, y2, z2;
  logic [DATA_W-1:0] amount;
  logic [DATA_W-1:0] acc;

  logic [KW-1:0]     n;
  logic [KW-1:0]     xl_k, yl_k, zl_k, xh_k, yh_k, zh_k;
  logic [KW-1:0]     xl_c, yl_c, zl_c;
  logic              point_ok;
  logic [KW-1:0]     cx, cy, cz;
  logic              accept;
  logic              out_free;

  logic [KW-1:0]     lb_i, lb_j, lb_k;
  logic [KW-1:0]     step_i, step_j, step_k;
  logic              i_more, j_more, k_more;
  logic [KW-1:0]     ni, nj, nk;
  logic              walk_done;

  logic [KW-1:0]     im1, jm1, km1;
  logic [AD-1:0]     cell_addr;
  logic              ram_we;
  logic [AD-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Effective side and corner clamping.
  always_comb begin
    n    = (KW'(side_size) > MAX_K) ? MAX_K : KW'(side_size);
    xl_k = KW'(x_low);
    yl_k = KW'(y_low);
    zl_k = KW'(z_low);
    xh_k = (KW'(x_high) > n) ? n : KW'(x_high);
    yh_k = (KW'(y_high) > n) ? n : KW'(y_high);
    zh_k = (KW'(z_high) > n) ? n : KW'(z_high);
    xl_c = (xl_k > n) ? n : xl_k;
    yl_c = (yl_k > n) ? n : yl_k;
    zl_c = (zl_k > n) ? n : zl_k;
    point_ok = (xl_k != '0) && (yl_k != '0) && (zl_k != '0) &&
               (xl_k <= n) && (yl_k <= n) && (zl_k <= n);
    // Corner bit set selects the lower bound of that axis.
    cx = corner[2] ? x1 : x2;
    cy = corner[1] ? y1 : y2;
    cz = corner[0] ? z1 : z2;
  end

  // One step of the tree walk: k fastest, then j, then i.
  always_comb begin
    lb_i   = i & (~i + KW'(1));
    lb_j   = j & (~j + KW'(1));
    lb_k   = k & (~k + KW'(1));
    step_i = up ? (i + lb_i) : (i - lb_i);
    step_j = up ? (j + lb_j) : (j - lb_j);
    step_k = up ? (k + lb_k) : (k - lb_k);
    i_more = up ? (step_i <= n) : (step_i != '0);
    j_more = up ? (step_j <= n) : (step_j != '0);
    k_more = up ? (step_k <= n) : (step_k != '0);
    ni = i;
    nj = j;
    nk = k;
    if (k_more) begin
      nk = step_k;
    end else if (j_more) begin
      nj = step_j;
      nk = sk;
    end else begin
      ni = step_i;
      nj = sj;
      nk = sk;
    end
    walk_done = !k_more && !j_more && !i_more;
  end

  always_comb begin
    im1       = i - KW'(1);
    jm1       = j - KW'(1);
    km1       = k - KW'(1);
    cell_addr = {im1[AW-1:0], jm1[AW-1:0], km1[AW-1:0]};
    ram_we    = (state == ST_CLEAR) || (state == ST_ADD_WR);
    ram_waddr = (state == ST_CLEAR) ? clr_addr : cell_addr;
    ram_wdata = (state == ST_CLEAR) ? '0 : (ram_rdata + amount);
  end

  ft3d_ram #(
    .ADDR_W (AD),
    .WIDTH  (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cell_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      side_size <= SIDE_RESET;
    end else begin
      if (cfg_write) begin
        side_size <= cfg_data;
      end
      if (out_valid && !out_stall && (state != ST_Q_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AD'(1);
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (cmd == CMD_ADD) begin
              // An add at a point outside the cube is dropped.
              if (point_ok) begin
                i      <= xl_k;
                j      <= yl_k;
                k      <= zl_k;
                sj     <= yl_k;
                sk     <= zl_k;
                up     <= 1'b1;
                amount <= value;
                state  <= ST_ADD_RD;
              end
            end else begin
              x2     <= xh_k;
              y2     <= yh_k;
              z2     <= zh_k;
              x1     <= (xl_c == '0) ? '0 : xl_c - KW'(1);
              y1     <= (yl_c == '0) ? '0 : yl_c - KW'(1);
              z1     <= (zl_c == '0) ? '0 : zl_c - KW'(1);
              corner <= '0;
              acc    <= '0;
              up     <= 1'b0;
              state  <= ST_Q_START;
            end
          end
        end
        ST_ADD_RD: begin
          state <= ST_ADD_WR;
        end
        ST_ADD_WR: begin
          if (walk_done) begin
            state <= ST_IDLE;
          end else begin
            i     <= ni;
            j     <= nj;
            k     <= nk;
            state <= ST_ADD_RD;
          end
        end
        ST_Q_START: begin
          // A prefix with any zero coordinate is empty and is skipped.
          if ((cx == '0) || (cy == '0) || (cz == '0)) begin
            if (corner == 3'd7) begin
              state <= ST_Q_DONE;
            end else begin
              corner <= corner + 3'd1;
            end
          end else begin
            i     <= cx;
            j     <= cy;
            k     <= cz;
            sj    <= cy;
            sk    <= cz;
            state <= ST_Q_RD;
          end
        end
        ST_Q_RD: begin
          state <= ST_Q_ACC;
        end
        ST_Q_ACC: begin
          // Corners with an odd number of lower bounds are subtracted.
          acc <= (^corner) ? (acc - ram_rdata) : (acc + ram_rdata);
          if (walk_done) begin
            if (corner == 3'd7) begin
              state <= ST_Q_DONE;
            end else begin
              corner <= corner + 3'd1;
              state  <= ST_Q_START;
            end
          end else begin
            i     <= ni;
            j     <= nj;
            k     <= nk;
            state <= ST_Q_RD;
          end
        end
        ST_Q_DONE: begin
          if (out_free) begin
            box_sum   <= acc;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/ft3d_checker.sv
// ----------------------------------------------------------------------------
// ft3d_port_checks
// Port-level checks on the 3-D binary indexed tree block, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module ft3d_port_checks import ft3d_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     cmd,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] box_sum
);

  // Reset starts the clearing pass, so nothing is taken and nothing is shown.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("input not stalled or output valid after reset");

  // A waiting sum must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(box_sum))
    else $error("stalled result changed or dropped");

  // A point add never produces a result transaction.
  a_add_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (cmd == CMD_ADD) && !out_valid |=> !out_valid)
    else $error("result appeared after a point add");

  // Once a box sum is taken, the input stalls while it runs.
  a_sum_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (cmd == CMD_SUM) |=> in_stall)
    else $error("input taken right after a box sum");

endmodule

bind fenwick_tree_3d_range_sum ft3d_port_checks u_ft3d_port_checks (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .cmd       (cmd),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .box_sum   (box_sum)
);

`default_nettype wire
